@@ src/bmv_pkg.sv @@
// ----------------------------------------------------------------------------
// bmv_pkg
// Shared types and constants for the brace markup validator.
// ----------------------------------------------------------------------------
package bmv_pkg;

    localparam int MAX_TAG_LEN_DEF = 64;
    localparam int MAX_DEPTH_DEF   = 255;

    localparam logic [15:0] CODE_OPEN  = 16'h0002;
    localparam logic [15:0] CODE_CLOSE = 16'h0003;
    localparam logic [15:0] CH_BSLASH  = 16'h005C;
    localparam logic [15:0] CH_LBRACE  = 16'h007B;
    localparam logic [15:0] CH_RBRACE  = 16'h007D;
    localparam logic [15:0] CH_SLASH   = 16'h002F;
    localparam logic [15:0] CH_ZERO    = 16'h0030;
    localparam logic [15:0] CH_NINE    = 16'h0039;

    typedef struct packed {
        logic [15:0] char_code;
        logic        last;
    } t_in;

    typedef struct packed {
        logic        emit;
        logic [15:0] out_char;
        logic        error;
        logic        done_res;
        logic        ok;
    } t_out;

endpackage

@@ src/brace_markup_validator.sv @@
// ----------------------------------------------------------------------------
// brace_markup_validator
// Checks and rewrites brace tag markup, one 16-bit character per beat.
// ----------------------------------------------------------------------------
// the result of an accepted beat is registered, in the skid register if the output stalls
// throughput: 1 character per cycle while o_ready is high; parse state updates in a single pass
// a skid register takes one extra beat while the output is stalled; o_ready is low while it is full
// reset: synchronous active-low i_rst_n clears parse state and the valid flags
// of both output registers; the block is ready as soon as reset is released
module brace_markup_validator #(
    parameter int MAX_TAG_LEN = bmv_pkg::MAX_TAG_LEN_DEF,
    parameter int MAX_DEPTH   = bmv_pkg::MAX_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bmv_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bmv_pkg::t_out o_data
);

    localparam int LW = $clog2(MAX_TAG_LEN + 1);
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int CW = (LW > DW) ? LW : DW;
    localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_TAG_LEN);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    // parse state
    logic          r_in_tag, n_in_tag;
    logic          r_esc, n_esc;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_slashes, n_slashes;
    logic          r_first_digit, n_first_digit;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_tag_seen, n_tag_seen;
    logic          r_err, n_err;

    // output register and skid
    logic          r_out_valid;
    bmv_pkg::t_out r_out;
    logic          r_skid_valid;
    bmv_pkg::t_out r_skid;

    bmv_pkg::t_out res;
    logic          push;
    logic          pop;
    logic [15:0]   ch;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign push    = i_valid && o_ready;
    assign pop     = r_out_valid && i_ready;
    assign ch      = i_data.char_code;

    always_comb begin
        n_in_tag      = r_in_tag;
        n_esc         = r_esc;
        n_len         = r_len;
        n_slashes     = r_slashes;
        n_first_digit = r_first_digit;
        n_depth       = r_depth;
        n_tag_seen    = r_tag_seen;
        n_err         = r_err;
        res           = '0;

        if (!r_err) begin
            if (r_esc) begin
                n_esc = 1'b0;
                if (ch inside {bmv_pkg::CH_BSLASH, bmv_pkg::CH_LBRACE,
                               bmv_pkg::CH_RBRACE}) begin
                    res.emit     = 1'b1;
                    res.out_char = ch;
                end else begin
                    n_err = 1'b1;
                end
            end else if (!r_in_tag) begin
                if (ch == bmv_pkg::CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (ch == bmv_pkg::CH_LBRACE) begin
                    n_in_tag      = 1'b1;
                    n_len         = '0;
                    n_slashes     = '0;
                    n_first_digit = 1'b0;
                    res.emit      = 1'b1;
                    res.out_char  = bmv_pkg::CODE_OPEN;
                end else if (ch == bmv_pkg::CH_RBRACE) begin
                    n_err = 1'b1;
                end else begin
                    res.emit     = 1'b1;
                    res.out_char = ch;
                end
            end else begin
                if (ch == bmv_pkg::CH_BSLASH || ch == bmv_pkg::CH_LBRACE) begin
                    n_err = 1'b1;
                end else if (ch == bmv_pkg::CH_RBRACE) begin
                    // close tag: plain opens a level unless digit-led, each slash closes one
                    if (r_len == '0 || r_len >= LEN_MAX) begin
                        n_err = 1'b1;
                    end else if (r_slashes == '0) begin
                        if (!r_first_digit && r_depth >= DEPTH_MAX) begin
                            n_err = 1'b1;
                        end else begin
                            if (!r_first_digit) begin
                                n_depth = r_depth + DW'(1);
                            end
                            n_tag_seen = 1'b1;
                            n_in_tag   = 1'b0;
                        end
                    end else if (r_slashes == r_len) begin
                        if (CW'(r_slashes) > CW'(r_depth)) begin
                            n_err = 1'b1;
                        end else begin
                            n_depth  = DW'(CW'(r_depth) - CW'(r_slashes));
                            n_in_tag = 1'b0;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                    if (!n_err) begin
                        res.emit     = 1'b1;
                        res.out_char = bmv_pkg::CODE_CLOSE;
                    end
                end else begin
                    if (r_len == '0) begin
                        n_first_digit = (ch >= bmv_pkg::CH_ZERO) &&
                                        (ch <= bmv_pkg::CH_NINE);
                    end
                    if (r_len < LEN_MAX) begin
                        n_len = r_len + LW'(1);
                    end
                    if (ch == bmv_pkg::CH_SLASH && r_slashes < LEN_MAX) begin
                        n_slashes = r_slashes + LW'(1);
                    end
                    res.emit     = 1'b1;
                    res.out_char = ch;
                end
            end
        end

        res.done_res = i_data.last;
        if (i_data.last) begin
            // a trailing backslash has nothing to escape
            if (n_esc) begin
                n_err = 1'b1;
            end
            res.ok = !n_err && !n_in_tag && (n_depth == '0) && n_tag_seen;
        end
        res.error = n_err;

        if (i_data.last) begin
            n_in_tag      = 1'b0;
            n_esc         = 1'b0;
            n_len         = '0;
            n_slashes     = '0;
            n_first_digit = 1'b0;
            n_depth       = '0;
            n_tag_seen    = 1'b0;
            n_err         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag      <= 1'b0;
            r_esc         <= 1'b0;
            r_len         <= '0;
            r_slashes     <= '0;
            r_first_digit <= 1'b0;
            r_depth       <= '0;
            r_tag_seen    <= 1'b0;
            r_err         <= 1'b0;
        end else if (push) begin
            r_in_tag      <= n_in_tag;
            r_esc         <= n_esc;
            r_len         <= n_len;
            r_slashes     <= n_slashes;
            r_first_digit <= n_first_digit;
            r_depth       <= n_depth;
            r_tag_seen    <= n_tag_seen;
            r_err         <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload side, no reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

endmodule

@@ src/bmv_checker.sv @@
// ----------------------------------------------------------------------------
// bmv_checker
// Port-level checks for the brace markup validator, bound to the top level.
// ----------------------------------------------------------------------------
module bmv_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_ready,
    input bmv_pkg::t_out o_data
);

    // a stalled result beat stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    a_ok_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.ok |-> o_data.done_res && !o_data.error)
        else $error("ok without done or with error");

    a_quiet_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.emit |-> o_data.out_char == 16'h0000)
        else $error("out_char nonzero without emit");

    a_no_emit_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.error |-> !o_data.emit)
        else $error("character emitted after an error");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind brace_markup_validator bmv_checker u_bmv_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

@@ tb/bmv_result_checker.sv @@
// ----------------------------------------------------------------------------
// bmv_result_checker
// Watches both channels of the brace markup validator, predicts the result
// beat of every accepted character and compares it field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bmv_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  bmv_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  bmv_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);

    localparam int TAG_LEN_CAP = bmv_pkg::MAX_TAG_LEN_DEF;
    localparam int DEPTH_CAP   = bmv_pkg::MAX_DEPTH_DEF;
    localparam int REPORT_MAX  = 10;

    logic       in_tag;
    logic       esc_pending;
    logic [6:0] tag_len;
    logic [6:0] tag_slashes;
    logic       first_digit;
    logic [7:0] depth;
    logic       tag_seen;
    logic       err_flag;

    bmv_pkg::t_out expected_q[$];
    bmv_pkg::t_out predicted;
    bmv_pkg::t_out want;
    logic          bad;
    int            fail_count = 0;

    function automatic void clear_parse();
        in_tag      = 1'b0;
        esc_pending = 1'b0;
        tag_len     = '0;
        tag_slashes = '0;
        first_digit = 1'b0;
        depth       = '0;
        tag_seen    = 1'b0;
        err_flag    = 1'b0;
    endfunction

    // closing brace inside a tag, returns 0 when a rule is broken
    function automatic bit close_tag_ok();
        if (tag_len == 0 || tag_len >= TAG_LEN_CAP) return 1'b0;
        if (tag_slashes == 0) begin
            if (!first_digit) begin
                if (depth >= DEPTH_CAP) return 1'b0;
                depth = depth + 8'd1;
            end
            tag_seen = 1'b1;
        end else if (tag_slashes == tag_len) begin
            if (tag_slashes > depth) return 1'b0;
            depth = depth - {1'b0, tag_slashes};
        end else begin
            return 1'b0;
        end
        in_tag = 1'b0;
        return 1'b1;
    endfunction

    function automatic bmv_pkg::t_out predict_result(input bmv_pkg::t_in beat);
        bmv_pkg::t_out res;
        logic          emit_b;
        logic [15:0]   oc;
        logic [15:0]   c;
        emit_b = 1'b0;
        oc     = '0;
        c      = beat.char_code;
        if (!err_flag) begin
            if (esc_pending) begin
                esc_pending = 1'b0;
                if (c == bmv_pkg::CH_BSLASH || c == bmv_pkg::CH_LBRACE
                    || c == bmv_pkg::CH_RBRACE) begin
                    emit_b = 1'b1;
                    oc     = c;
                end else begin
                    err_flag = 1'b1;
                end
            end else if (!in_tag) begin
                if (c == bmv_pkg::CH_BSLASH) begin
                    esc_pending = 1'b1;
                end else if (c == bmv_pkg::CH_LBRACE) begin
                    in_tag      = 1'b1;
                    tag_len     = '0;
                    tag_slashes = '0;
                    first_digit = 1'b0;
                    emit_b      = 1'b1;
                    oc          = bmv_pkg::CODE_OPEN;
                end else if (c == bmv_pkg::CH_RBRACE) begin
                    err_flag = 1'b1;
                end else begin
                    emit_b = 1'b1;
                    oc     = c;
                end
            end else begin
                if (c == bmv_pkg::CH_BSLASH || c == bmv_pkg::CH_LBRACE) begin
                    err_flag = 1'b1;
                end else if (c == bmv_pkg::CH_RBRACE) begin
                    if (close_tag_ok()) begin
                        emit_b = 1'b1;
                        oc     = bmv_pkg::CODE_CLOSE;
                    end else begin
                        err_flag = 1'b1;
                    end
                end else begin
                    if (tag_len == 0)
                        first_digit = (c >= bmv_pkg::CH_ZERO && c <= bmv_pkg::CH_NINE);
                    if (tag_len < TAG_LEN_CAP) tag_len = tag_len + 7'd1;
                    if (c == bmv_pkg::CH_SLASH && tag_slashes < TAG_LEN_CAP)
                        tag_slashes = tag_slashes + 7'd1;
                    emit_b = 1'b1;
                    oc     = c;
                end
            end
        end
        res.ok = 1'b0;
        if (beat.last) begin
            // a backslash with nothing after it
            if (esc_pending) err_flag = 1'b1;
            res.ok = !err_flag && !in_tag && depth == 0 && tag_seen;
        end
        res.emit     = emit_b;
        res.out_char = emit_b ? oc : 16'h0000;
        res.error    = err_flag;
        res.done_res = beat.last;
        if (beat.last) clear_parse();
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                predicted = predict_result(i_in_data);
                expected_q.insert(expected_q.size(), predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("result beat with nothing expected: %h", i_out_data);
                end else begin
                    want = expected_q.pop_front();
                    bad  = (i_out_data.emit !== want.emit)
                        || (i_out_data.out_char !== want.out_char)
                        || (i_out_data.error !== want.error)
                        || (i_out_data.done_res !== want.done_res)
                        || (i_out_data.ok !== want.ok);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"mismatch exp/got: emit %0b/%0b out_char %h/%h ",
                                      "error %0b/%0b done_res %0b/%0b ok %0b/%0b"},
                                     want.emit, i_out_data.emit,
                                     want.out_char, i_out_data.out_char,
                                     want.error, i_out_data.error,
                                     want.done_res, i_out_data.done_res,
                                     want.ok, i_out_data.ok);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_q.size();
    end

endmodule

@@ tb/brace_markup_validator_test.sv @@
// ----------------------------------------------------------------------------
// brace_markup_validator_test
// Drives brace markup strings into the validator: a few directed strings for
// escapes, tag rules and the nesting limit, then random markup, mostly well
// formed with some noise. Both sides idle at random; the checker predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module brace_markup_validator_test;

    localparam int          ITEM_TARGET  = 1150;
    localparam int          IDLE_LIMIT   = 4000;
    localparam int          TAG_LEN_MAX  = bmv_pkg::MAX_TAG_LEN_DEF;
    localparam logic [15:0] CH_NUL       = 16'h0000;
    localparam logic [15:0] CH_ALL_ONES  = 16'hFFFF;
    localparam logic [15:0] CH_SPACE     = 16'h0020;
    localparam logic [15:0] CH_TILDE     = 16'h007E;
    localparam logic [15:0] CH_LOW_A     = 16'h0061;
    localparam logic [15:0] CH_LOW_Z     = 16'h007A;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    bmv_pkg::t_in  i_data  = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    bmv_pkg::t_out o_data;

    int            fail_count;
    int            pending;
    int            idle_cycles   = 0;
    int            sent_items    = 0;
    bit            sender_calm   = 1'b0;
    bit            receiver_calm = 1'b0;
    bmv_pkg::t_in  text_q[$];

    brace_markup_validator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    bmv_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones, none at all while calm
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [15:0] rand_plain(input bit no_slash);
        logic [15:0] c;
        do begin
            if ($urandom_range(0, 3) == 0) c = 16'($urandom_range(0, 65535));
            else c = 16'($urandom_range(CH_SPACE, CH_TILDE));
        end while (c == bmv_pkg::CH_BSLASH || c == bmv_pkg::CH_LBRACE
                   || c == bmv_pkg::CH_RBRACE
                   || (no_slash && c == bmv_pkg::CH_SLASH));
        return c;
    endfunction

    task automatic put_char(input logic [15:0] c);
        bmv_pkg::t_in b;
        b.char_code = c;
        b.last      = 1'b0;
        text_q.insert(text_q.size(), b);
    endtask

    task automatic put_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) put_char({8'h00, s[k]});
    endtask

    task automatic put_open(input int len, input bit digit_first);
        int k;
        put_char(bmv_pkg::CH_LBRACE);
        if (digit_first) put_char(bmv_pkg::CH_ZERO + 16'($urandom_range(0, 9)));
        else put_char(16'($urandom_range(CH_LOW_A, CH_LOW_Z)));
        for (k = 1; k < len; k++) put_char(rand_plain(1'b1));
        put_char(bmv_pkg::CH_RBRACE);
    endtask

    task automatic put_close(input int levels);
        put_char(bmv_pkg::CH_LBRACE);
        repeat (levels) put_char(bmv_pkg::CH_SLASH);
        put_char(bmv_pkg::CH_RBRACE);
    endtask

    task automatic put_noise();
        case ($urandom_range(0, 6))
            0: put_char(bmv_pkg::CH_BSLASH);
            1: put_char(bmv_pkg::CH_LBRACE);
            2: put_char(bmv_pkg::CH_RBRACE);
            3: put_char(bmv_pkg::CH_SLASH);
            4: put_text("{}");
            5: begin
                // slashes mixed with other characters
                put_char(bmv_pkg::CH_LBRACE);
                put_char(rand_plain(1'b1));
                put_char(bmv_pkg::CH_SLASH);
                put_char(bmv_pkg::CH_RBRACE);
            end
            default: put_char(16'($urandom_range(0, 65535)));
        endcase
    endtask

    // marks the final character and sends the whole string
    task automatic send_text();
        bmv_pkg::t_in b;
        int           gap;
        int           k;
        if (text_q.size() == 0) put_char(CH_LOW_A);
        b      = text_q[text_q.size() - 1];
        b.last = 1'b1;
        text_q[text_q.size() - 1] = b;
        sent_items += text_q.size();
        for (k = 0; k < text_q.size(); k++) begin
            gap = pick_gap(sender_calm);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data  <= text_q[k];
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
        end
        text_q.delete();
    endtask

    task automatic compose_markup();
        int open_now;
        int tokens;
        int kind;
        int n;
        int k;
        bit digit;
        open_now = 0;
        tokens   = $urandom_range(1, 8);
        for (k = 0; k < tokens; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                repeat ($urandom_range(1, 4)) put_char(rand_plain(1'b0));
            end else if (kind < 40) begin
                put_char(bmv_pkg::CH_BSLASH);
                case ($urandom_range(0, 2))
                    0: put_char(bmv_pkg::CH_BSLASH);
                    1: put_char(bmv_pkg::CH_LBRACE);
                    default: put_char(bmv_pkg::CH_RBRACE);
                endcase
            end else if (kind < 68) begin
                // now and then a tag right at the length limit
                if ($urandom_range(0, 19) == 0)
                    n = $urandom_range(TAG_LEN_MAX - 2, TAG_LEN_MAX + 1);
                else
                    n = $urandom_range(1, 5);
                digit = ($urandom_range(0, 4) == 0);
                put_open(n, digit);
                if (!digit && n < TAG_LEN_MAX) open_now++;
            end else if (kind < 88) begin
                // with nothing open this goes below zero
                n = (open_now > 0) ? $urandom_range(1, (open_now < 4) ? open_now : 4) : 1;
                put_close(n);
                open_now = (open_now > n) ? open_now - n : 0;
            end else begin
                put_noise();
            end
        end
        if ($urandom_range(0, 9) < 8) begin
            while (open_now > 0) begin
                n = (open_now < TAG_LEN_MAX - 1) ? open_now : TAG_LEN_MAX - 1;
                put_close(n);
                open_now -= n;
            end
        end
        send_text();
    endtask

    // longest all-slash close, then nesting up to the limit and one past it
    task automatic run_deep_nesting();
        repeat (TAG_LEN_MAX - 1) put_text("{a}");
        put_close(TAG_LEN_MAX - 1);
        repeat (bmv_pkg::MAX_DEPTH_DEF) put_text("{a}");
        put_text("{z}");
        put_text("x");
        send_text();
    endtask

    initial begin : receiver
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 99) < 3) receiver_calm = !receiver_calm;
            stall = pick_gap(receiver_calm);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // valid string with field extremes, control codes as text and escapes
        put_text("{a}");
        put_char(CH_ALL_ONES);
        put_char(CH_NUL);
        put_char(bmv_pkg::CODE_OPEN);
        put_char(bmv_pkg::CODE_CLOSE);
        put_text("\\\\\\{\\}{/}");
        send_text();
        put_text("}");
        send_text();
        put_text("\\");
        send_text();
        put_text("{\\}");
        send_text();
        put_text("{}");
        send_text();
        put_text("{7}");
        send_text();
        put_text("{a/}");
        send_text();

        run_deep_nesting();

        while (sent_items < ITEM_TARGET) begin
            sender_calm = ($urandom_range(0, 4) == 0);
            compose_markup();
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
